// File: rtl/pem_pkg.sv
// pem_pkg: shared sizes, codes and types for the peer endpoint mapper.
// No dependencies; used by every file under rtl.
`timescale 1ns / 1ps

package pem_pkg;

	localparam int TABLE_SLOTS = 8;
	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

	localparam int MAC_W   = 48;
	localparam int BUSY_W  = 4;
	localparam int EP_W    = 3;
	localparam int MAP_W   = 4;
	localparam int STAT_W  = 3;
	localparam int PEND_W  = 8;
	localparam int DSLOT_W = 3;

	// bit 0 of the first octet marks group addresses
	localparam int MCAST_BIT = 40;

	localparam logic [EP_W-1:0]   EP_MIN   = 3'd2;
	localparam logic [EP_W-1:0]   EP_MAX   = 3'd5;
	localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;

	typedef enum logic [STAT_W-1:0] {
		ST_KNOWN = 3'd0,
		ST_NEW   = 3'd1,
		ST_MCAST = 3'd2,
		ST_FULL  = 3'd3,
		ST_DONE  = 3'd4
	} status_t;

	// update request from the sequencer to the peer table
	typedef struct packed {
		logic              addr_we;
		logic              pend_inc;
		logic              pend_dec;
		logic [MAC_W-1:0]  mac;
		logic [EP_W-1:0]   ep;
	} tbl_cmd_t;

	// entry read from the peer table at the current index
	typedef struct packed {
		logic [MAC_W-1:0]  addr;
		logic [EP_W-1:0]   ep;
		logic [PEND_W-1:0] pend;
	} tbl_rd_t;

endpackage

// File: rtl/peer_endpoint_mapper_core.sv
// Peer endpoint mapper top level: sequencer walking the peer table one slot
// per cycle. Uses pem_pkg, pem_table and pem_ep_pick.
//
// Input channel (in_valid/in_stall) carries one transaction: mode, dest_mac,
// endpoint_busy, done_slot. Output channel (out_valid/out_stall) returns one
// transaction per input: endpoint, map_number, status.
// Mode 0 looks dest_mac up in the table by walking the slots in use through
// one 48-bit comparator, one slot per cycle; a new peer adds a step for the
// table write. Mode 1 and multicast frames skip the walk.
// After input accept, multicast goes straight to the emit step, a completion
// reads its done slot first, and a lookup emits after its walk and any write.
// The walk length, set by the number of slots in use, sets the rate; a new
// transaction is taken only while the sequencer is idle.
// A finished result sits in the output register; the next transaction may be
// accepted meanwhile, and the sequencer waits in its emit step while
// out_stall holds the previous result.
// Reset (arst_n low) clears all pending counts, the slot count, the output
// valid and sets the round-robin pointer to endpoint 2.
`timescale 1ns / 1ps

module peer_endpoint_mapper_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [pem_pkg::MAC_W-1:0]   dest_mac,
	input  logic [pem_pkg::BUSY_W-1:0]  endpoint_busy,
	input  logic [pem_pkg::DSLOT_W-1:0] done_slot,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pem_pkg::EP_W-1:0]    endpoint,
	output logic [pem_pkg::MAP_W-1:0]   map_number,
	output logic [pem_pkg::STAT_W-1:0]  status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_COMPLETE,
		S_EMIT
	} state_t;

	state_t                       state_q;
	logic [pem_pkg::MAC_W-1:0]    mac_q;
	logic [pem_pkg::BUSY_W-1:0]   busy_q;
	logic [pem_pkg::DSLOT_W-1:0]  slot_q;
	logic [pem_pkg::CNT_W-1:0]    idx_q;
	logic [pem_pkg::CNT_W-1:0]    count_q;
	logic [pem_pkg::SLOT_W-1:0]   free_q;
	logic                         have_free_q;
	logic [pem_pkg::EP_W-1:0]     res_ep_q;
	logic [pem_pkg::MAP_W-1:0]    res_map_q;
	pem_pkg::status_t             res_st_q;
	logic                         out_valid_q;
	logic [pem_pkg::EP_W-1:0]     endpoint_q;
	logic [pem_pkg::MAP_W-1:0]    map_number_q;
	logic [pem_pkg::STAT_W-1:0]   status_q;

	logic [pem_pkg::SLOT_W-1:0]   tbl_idx;
	pem_pkg::tbl_cmd_t            tbl_cmd;
	pem_pkg::tbl_rd_t             tbl_rd;
	logic [pem_pkg::EP_W-1:0]     pick_ep;
	logic                         scan_end;
	logic                         hit;
	logic                         slot_used;
	logic                         in_acc;
	logic                         out_free;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign scan_end  = (idx_q >= count_q);
	assign hit       = (tbl_rd.addr == mac_q);
	assign slot_used = (pem_pkg::CNT_W'(slot_q) < count_q);

	always_comb begin
		unique case (state_q)
			S_COMPLETE: tbl_idx = pem_pkg::SLOT_W'(slot_q);
			S_WRITE:    tbl_idx = free_q;
			default:    tbl_idx = idx_q[pem_pkg::SLOT_W-1:0];
		endcase
	end

	always_comb begin
		tbl_cmd          = '0;
		tbl_cmd.mac      = mac_q;
		tbl_cmd.ep       = pick_ep;
		unique case (state_q)
			S_SCAN: begin
				tbl_cmd.pend_inc = !scan_end && hit;
			end
			S_WRITE: begin
				tbl_cmd.addr_we  = 1'b1;
				tbl_cmd.pend_inc = 1'b1;
			end
			S_COMPLETE: begin
				tbl_cmd.pend_dec = slot_used;
			end
			default: ;
		endcase
	end

	pem_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (tbl_idx),
		.cmd    (tbl_cmd),
		.rd     (tbl_rd)
	);

	pem_ep_pick u_pick (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (busy_q),
		.commit (state_q == S_WRITE),
		.ep     (pick_ep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			count_q      <= '0;
			free_q       <= '0;
			have_free_q  <= 1'b0;
			res_ep_q     <= pem_pkg::EP_MIN;
			res_map_q    <= '0;
			res_st_q     <= pem_pkg::ST_KNOWN;
			out_valid_q  <= 1'b0;
			endpoint_q   <= pem_pkg::EP_MIN;
			map_number_q <= '0;
			status_q     <= '0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						idx_q       <= '0;
						have_free_q <= 1'b0;
						if (mode) begin
							state_q <= S_COMPLETE;
						end else if (dest_mac[pem_pkg::MCAST_BIT]) begin
							res_ep_q  <= pem_pkg::EP_MIN;
							res_map_q <= '0;
							res_st_q  <= pem_pkg::ST_MCAST;
							state_q   <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						if (have_free_q) begin
							state_q <= S_WRITE;
						end else if (count_q >= pem_pkg::CNT_W'(pem_pkg::TABLE_SLOTS)) begin
							res_ep_q  <= pem_pkg::EP_MIN;
							res_map_q <= '0;
							res_st_q  <= pem_pkg::ST_FULL;
							state_q   <= S_EMIT;
						end else begin
							free_q  <= count_q[pem_pkg::SLOT_W-1:0];
							count_q <= count_q + 1'b1;
							state_q <= S_WRITE;
						end
					end else if (hit) begin
						res_ep_q  <= tbl_rd.ep;
						res_map_q <= pem_pkg::MAP_W'(idx_q) + 1'b1;
						res_st_q  <= pem_pkg::ST_KNOWN;
						state_q   <= S_EMIT;
					end else begin
						// remember the first idle slot for reuse
						if (!have_free_q && tbl_rd.pend == '0) begin
							free_q      <= idx_q[pem_pkg::SLOT_W-1:0];
							have_free_q <= 1'b1;
						end
						idx_q <= idx_q + 1'b1;
					end
				end
				S_WRITE: begin
					res_ep_q  <= pick_ep;
					res_map_q <= pem_pkg::MAP_W'(free_q) + 1'b1;
					res_st_q  <= pem_pkg::ST_NEW;
					state_q   <= S_EMIT;
				end
				S_COMPLETE: begin
					if (slot_used) begin
						res_ep_q  <= tbl_rd.ep;
						res_map_q <= pem_pkg::MAP_W'(slot_q) + 1'b1;
					end else begin
						res_ep_q  <= pem_pkg::EP_MIN;
						res_map_q <= '0;
					end
					res_st_q <= pem_pkg::ST_DONE;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						endpoint_q   <= res_ep_q;
						map_number_q <= res_map_q;
						status_q     <= res_st_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mac_q  <= dest_mac;
			busy_q <= endpoint_busy;
			slot_q <= done_slot;
		end
	end

	assign out_valid  = out_valid_q;
	assign endpoint   = endpoint_q;
	assign map_number = map_number_q;
	assign status     = status_q;

endmodule

// File: rtl/pem_table.sv
// pem_table: peer address/endpoint store with saturating pending counters.
// One index serves read, address compare source and update. Uses pem_pkg.
`timescale 1ns / 1ps

module pem_table (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [pem_pkg::SLOT_W-1:0] idx,
	input  pem_pkg::tbl_cmd_t        cmd,
	output pem_pkg::tbl_rd_t         rd
);

	logic [pem_pkg::MAC_W-1:0]  peer_addr_q [pem_pkg::TABLE_SLOTS];
	logic [pem_pkg::EP_W-1:0]   peer_ep_q   [pem_pkg::TABLE_SLOTS];
	logic [pem_pkg::PEND_W-1:0] peer_pend_q [pem_pkg::TABLE_SLOTS];
	logic [pem_pkg::PEND_W-1:0] pend_nxt;

	assign rd.addr = peer_addr_q[idx];
	assign rd.ep   = peer_ep_q[idx];
	assign rd.pend = peer_pend_q[idx];

	// single saturating up/down unit shared by all slots
	always_comb begin
		pend_nxt = rd.pend;
		if (cmd.pend_inc && rd.pend != pem_pkg::PEND_MAX) begin
			pend_nxt = rd.pend + 1'b1;
		end else if (cmd.pend_dec && rd.pend != '0) begin
			pend_nxt = rd.pend - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.addr_we) begin
			peer_addr_q[idx] <= cmd.mac;
			peer_ep_q[idx]   <= cmd.ep;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pem_pkg::TABLE_SLOTS; i++) begin
				peer_pend_q[i] <= '0;
			end
		end else if (cmd.pend_inc || cmd.pend_dec) begin
			peer_pend_q[idx] <= pend_nxt;
		end
	end

endmodule

// File: rtl/pem_ep_pick.sv
// pem_ep_pick: lowest idle endpoint, else round-robin pointer (2..5).
// Pointer advances only on a committed pick with all endpoints busy. Uses pem_pkg.
`timescale 1ns / 1ps

module pem_ep_pick (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [pem_pkg::BUSY_W-1:0] busy,
	input  logic                       commit,
	output logic [pem_pkg::EP_W-1:0]   ep
);

	logic [pem_pkg::EP_W-1:0] rr_q;
	logic                     all_busy;

	assign all_busy = &busy;

	always_comb begin
		ep = rr_q;
		for (int k = pem_pkg::BUSY_W - 1; k >= 0; k--) begin
			if (!busy[k]) begin
				ep = pem_pkg::EP_MIN + pem_pkg::EP_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q <= pem_pkg::EP_MIN;
		end else if (commit && all_busy) begin
			rr_q <= (rr_q >= pem_pkg::EP_MAX) ? pem_pkg::EP_MIN : rr_q + 1'b1;
		end
	end

endmodule
